// File: rtl/proxy_response_frame_parser_unit_defines.svh
// Assertion macros shared by the response frame parser RTL.
`ifndef PROXY_RESPONSE_FRAME_PARSER_UNIT_DEFINES_SVH
`define PROXY_RESPONSE_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRFP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/prfp_pkg.sv
// Types and constants of the proxy response frame parser.
`timescale 1ns / 1ps

package prfp_pkg;

    localparam logic [31:0] MAGIC_WORD   = 32'h3158_504e;
    localparam int          RESULT_BYTES = 8;
    localparam int          HEADER_BYTES = 8;
    localparam int          MAGIC_BYTES  = 4;

    typedef enum logic [1:0] {
        CFG_EXPECTED_OP   = 2'd0,
        CFG_OUT_CAPACITY  = 2'd1,
        CFG_STRICT_LENGTH = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_OP_MISM   = 2'd2,
        ST_SHORT     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        logic               done_res;
        t_status            status;
        logic signed [63:0] result_value;
        logic [31:0]        response_length;
    } t_result;

endpackage

// File: rtl/proxy_response_frame_parser_unit.sv
// Top level of the proxy response frame parser.
// A result word is registered in the output register, or in the skid register while held.
// Throughput: one byte per cycle unless o_in_stall; a single compare-and-shift step.
// An output register plus one skid register keep input accepting while a result waits.
// Reset (synchronous, active low) returns the parser to magic search, clears config and valids.
`timescale 1ns / 1ps
`include "proxy_response_frame_parser_unit_defines.svh"

module proxy_response_frame_parser_unit
    import prfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_data_valid,
    output logic [7:0]         o_data_byte,
    output logic               o_done_res,
    output logic [1:0]         o_status,
    output logic signed [63:0] o_result_value,
    output logic [31:0]        o_response_length,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic [6:0]  r_exp_op;
    logic [15:0] r_capacity;
    logic        r_strict;

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_magic, n_magic;
    logic [7:0]  r_op, n_op;
    logic [31:0] r_length, n_length;
    logic [63:0] r_result, n_result;
    logic [15:0] r_fwd, n_fwd;

    t_result     res;
    logic        res_valid;
    logic        restart;
    logic [31:0] len_m1;
    logic        in_acc;
    logic        out_take;

    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign len_m1      = r_length - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_op   <= '0;
            r_capacity <= '0;
            r_strict   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_EXPECTED_OP:   r_exp_op   <= i_cfg_data[6:0];
                CFG_OUT_CAPACITY:  r_capacity <= i_cfg_data;
                CFG_STRICT_LENGTH: r_strict   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_magic   = r_magic;
        n_op      = r_op;
        n_length  = r_length;
        n_result  = r_result;
        n_fwd     = r_fwd;
        res       = '0;
        res_valid = 1'b0;
        restart   = 1'b0;
        case (r_phase)
            PH_MAGIC: begin
                n_magic = {i_rx_byte, r_magic[31:8]};
                n_count = r_count + 32'd1;
                if (r_count == 32'(MAGIC_BYTES - 1)) begin
                    if (n_magic != MAGIC_WORD) begin
                        restart      = 1'b1;
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.status   = ST_BAD_MAGIC;
                    end else begin
                        n_phase = PH_HEADER;
                        n_count = '0;
                    end
                end
            end
            PH_HEADER: begin
                if (r_count == 32'd0) begin
                    n_op = i_rx_byte;
                end
                if (r_count >= 32'(HEADER_BYTES - 4)) begin
                    n_length = {i_rx_byte, r_length[31:8]};
                end
                n_count = r_count + 32'd1;
                if (r_count == 32'(HEADER_BYTES - 1)) begin
                    if (n_op != {1'b1, r_exp_op}) begin
                        restart             = 1'b1;
                        res_valid           = 1'b1;
                        res.done_res        = 1'b1;
                        res.status          = ST_OP_MISM;
                        res.response_length = n_length;
                    end else if (n_length == 32'd0) begin
                        restart      = 1'b1;
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        if (r_strict) begin
                            res.status = ST_SHORT;
                        end else begin
                            res.status = ST_OK;
                        end
                    end else begin
                        n_phase  = PH_PAYLOAD;
                        n_count  = '0;
                        n_result = '0;
                        n_fwd    = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_length < 32'(RESULT_BYTES)) begin
                    // Short payload: drain it and flag on its last byte.
                    if (r_count == len_m1) begin
                        restart             = 1'b1;
                        res_valid           = 1'b1;
                        res.done_res        = 1'b1;
                        res.status          = ST_SHORT;
                        res.response_length = r_length;
                    end else begin
                        n_count = r_count + 32'd1;
                    end
                end else begin
                    if (r_count < 32'(RESULT_BYTES)) begin
                        n_result = {i_rx_byte, r_result[63:8]};
                    end else if (r_fwd < r_capacity) begin
                        res.data_valid = 1'b1;
                        res.data_byte  = i_rx_byte;
                        n_fwd          = r_fwd + 16'd1;
                    end
                    res.result_value    = n_result;
                    res.response_length = r_length;
                    if (r_count == len_m1) begin
                        restart      = 1'b1;
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                    end else begin
                        n_count   = r_count + 32'd1;
                        res_valid = res.data_valid;
                    end
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase
        if (restart) begin
            n_phase  = PH_MAGIC;
            n_count  = '0;
            n_magic  = '0;
            n_op     = '0;
            n_length = '0;
            n_result = '0;
            n_fwd    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_count  <= '0;
            r_magic  <= '0;
            r_op     <= '0;
            r_length <= '0;
            r_result <= '0;
            r_fwd    <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_magic  <= n_magic;
            r_op     <= n_op;
            r_length <= n_length;
            r_result <= n_result;
            r_fwd    <= n_fwd;
        end
    end

    // A new word goes to the skid register only while the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_valid      = r_out.data_valid;
    assign o_data_byte       = r_out.data_byte;
    assign o_done_res        = r_out.done_res;
    assign o_status          = r_out.status;
    assign o_result_value    = r_out.result_value;
    assign o_response_length = r_out.response_length;

    `PRFP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PRFP_ASSERT_NOW(a_word_has_meaning, i_clk, i_rst_n, r_out_valid,
                     r_out.data_valid || r_out.done_res)
    `PRFP_ASSERT_NOW(a_error_no_data, i_clk, i_rst_n,
                     r_out_valid && r_out.status != ST_OK,
                     !r_out.data_valid && r_out.result_value == 64'sd0)
    `PRFP_ASSERT_NOW(a_payload_nonempty, i_clk, i_rst_n, r_phase == PH_PAYLOAD,
                     r_length != 32'd0)
    `PRFP_ASSERT_NEXT(a_done_restarts, i_clk, i_rst_n, in_acc && res_valid && res.done_res,
                      r_phase == PH_MAGIC && r_count == 32'd0)

endmodule
